// ===== hdl/brle_pkg.sv =====
package brle_pkg;

  localparam int unsigned LANES_DEF = 8;
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned GROUP_W = 64;
  localparam int unsigned COUNT_W = 4;

  localparam logic CFG_RLE4_MODE = 1'b0;
  localparam logic CFG_LINE_CAPACITY = 1'b1;

  localparam logic [7:0] ESC_EOL = 8'd0;
  localparam logic [7:0] ESC_EOB = 8'd1;
  localparam logic [7:0] ESC_DELTA = 8'd2;
  localparam logic [7:0] ESC_ABS_MIN = 8'd3;

  typedef enum logic [2:0] {
    ST_DATA     = 3'd0,
    ST_EOL      = 3'd1,
    ST_EOB      = 3'd2,
    ST_DELTA    = 3'd3,
    ST_OVERFLOW = 3'd4,
    ST_TRUNC    = 3'd5
  } status_t;

  typedef enum logic [2:0] {
    PH_COUNT  = 3'd0,
    PH_VALUE  = 3'd1,
    PH_ESCAPE = 3'd2,
    PH_ABS    = 3'd3,
    PH_PAD    = 3'd4
  } phase_t;

  // one queued job: len pixels from value, then an optional status
  typedef struct packed {
    logic [7:0] value;
    logic [7:0] len;
    logic       r4;
    status_t    st;
  } cmd_t;

endpackage

// ===== hdl/brle_front.sv =====
module brle_front #(
  parameter int unsigned LANES = brle_pkg::LANES_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           rle4_mode,
  input  logic [15:0]    line_capacity,
  input  logic           accept,
  input  logic [7:0]     code_byte,
  input  logic           stream_end,
  output logic           push,
  output brle_pkg::cmd_t cmd
);
  import brle_pkg::*;

  phase_t      phase_r, phase_nxt;
  logic [7:0]  run_len_r, run_len_nxt;
  logic [7:0]  abs_rem_r, abs_rem_nxt;
  logic        pad_r, pad_nxt;
  logic [15:0] pix_wr_r, pix_wr_nxt;

  logic        ovf;
  logic [7:0]  take;
  logic [7:0]  abs_left;
  logic [8:0]  byte_inc;
  status_t     esc_st;

  assign ovf = ({1'b0, pix_wr_r} + {9'd0, code_byte}) > {1'b0, line_capacity};
  assign byte_inc = {1'b0, code_byte} + 9'd1;
  assign abs_left = abs_rem_r - take;

  always_comb begin
    if (abs_rem_r == 8'd0) begin
      take = 8'd0;
    end else if (rle4_mode && abs_rem_r >= 8'd2 && LANES >= 2) begin
      take = 8'd2;
    end else begin
      take = 8'd1;
    end
  end

  always_comb begin
    unique case (code_byte)
      ESC_EOL:   esc_st = ST_EOL;
      ESC_EOB:   esc_st = ST_EOB;
      ESC_DELTA: esc_st = ST_DELTA;
      default:   esc_st = ST_DATA;
    endcase
  end

  always_comb begin
    phase_nxt = phase_r;
    run_len_nxt = run_len_r;
    abs_rem_nxt = abs_rem_r;
    pad_nxt = pad_r;
    pix_wr_nxt = pix_wr_r;
    if (accept) begin
      unique case (phase_r)
        PH_VALUE: begin
          pix_wr_nxt = pix_wr_r + {8'd0, run_len_r};
          run_len_nxt = 8'd0;
          phase_nxt = PH_COUNT;
        end
        PH_ESCAPE: begin
          if (code_byte < ESC_ABS_MIN || ovf) begin
            phase_nxt = PH_COUNT;
            run_len_nxt = 8'd0;
            abs_rem_nxt = 8'd0;
            pad_nxt = 1'b0;
            pix_wr_nxt = 16'd0;
          end else begin
            abs_rem_nxt = code_byte;
            pad_nxt = rle4_mode ? byte_inc[1] : code_byte[0];
            phase_nxt = PH_ABS;
          end
        end
        PH_ABS: begin
          abs_rem_nxt = abs_left;
          pix_wr_nxt = pix_wr_r + {8'd0, take};
          if (abs_left == 8'd0) begin
            phase_nxt = pad_r ? PH_PAD : PH_COUNT;
            pad_nxt = 1'b0;
          end
        end
        PH_PAD: begin
          phase_nxt = PH_COUNT;
        end
        default: begin
          if (code_byte == 8'd0) begin
            phase_nxt = PH_ESCAPE;
          end else if (!stream_end && ovf) begin
            phase_nxt = PH_COUNT;
            run_len_nxt = 8'd0;
            abs_rem_nxt = 8'd0;
            pad_nxt = 1'b0;
            pix_wr_nxt = 16'd0;
          end else begin
            run_len_nxt = code_byte;
            phase_nxt = PH_VALUE;
          end
        end
      endcase
      if (stream_end) begin
        phase_nxt = PH_COUNT;
        run_len_nxt = 8'd0;
        abs_rem_nxt = 8'd0;
        pad_nxt = 1'b0;
        pix_wr_nxt = 16'd0;
      end
    end
  end

  always_comb begin
    cmd.value = code_byte;
    cmd.len = 8'd0;
    cmd.r4 = rle4_mode;
    cmd.st = ST_DATA;
    unique case (phase_r)
      PH_VALUE: begin
        cmd.len = run_len_r;
      end
      PH_ESCAPE: begin
        if (code_byte < ESC_ABS_MIN) begin
          cmd.st = esc_st;
        end else if (ovf) begin
          cmd.st = ST_OVERFLOW;
        end
      end
      PH_ABS: begin
        cmd.len = take;
      end
      PH_PAD: begin
        cmd.len = 8'd0;
      end
      default: begin
        if (code_byte != 8'd0 && !stream_end && ovf) begin
          cmd.st = ST_OVERFLOW;
        end
      end
    endcase
    if (stream_end && cmd.st == ST_DATA) begin
      cmd.st = ST_TRUNC;
    end
    if (phase_r != PH_VALUE && phase_r != PH_ABS && phase_r != PH_ESCAPE
        && phase_r != PH_PAD && stream_end) begin
      cmd.st = ST_TRUNC;
    end
    push = accept && (cmd.len != 8'd0 || cmd.st != ST_DATA);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_COUNT;
      run_len_r <= 8'd0;
      abs_rem_r <= 8'd0;
      pad_r <= 1'b0;
      pix_wr_r <= 16'd0;
    end else begin
      phase_r <= phase_nxt;
      run_len_r <= run_len_nxt;
      abs_rem_r <= abs_rem_nxt;
      pad_r <= pad_nxt;
      pix_wr_r <= pix_wr_nxt;
    end
  end

endmodule

// ===== hdl/brle_queue.sv =====
module brle_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  brle_pkg::cmd_t push_cmd,
  input  logic           pop,
  output brle_pkg::cmd_t head,
  output logic           empty,
  output logic           full
);
  import brle_pkg::*;

  localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

  cmd_t             slot_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] fill_r, fill_nxt;
  logic             do_push, do_pop;

  assign empty = (fill_r == CNT_W'(0));
  assign full = (fill_r == CNT_W'(QUEUE_DEPTH));
  assign do_push = push && !full;
  assign do_pop = pop && !empty;
  assign head = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    fill_nxt = fill_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? PTR_W'(0) : wr_ptr_r + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? PTR_W'(0) : rd_ptr_r + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      fill_nxt = fill_r + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      fill_nxt = fill_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r <= fill_nxt;
    end
  end

endmodule

// ===== hdl/brle_back.sv =====
module brle_back #(
  parameter int unsigned LANES = brle_pkg::LANES_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  brle_pkg::cmd_t                  head,
  input  logic                            empty,
  output logic                            pop,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [brle_pkg::GROUP_W-1:0]    out_pixel_group,
  output logic [brle_pkg::COUNT_W-1:0]    out_pixel_count,
  output logic [2:0]                      out_status,
  output logic                            out_last_of_run
);
  import brle_pkg::*;

  localparam logic [7:0] LANES_B = 8'(LANES);

  logic [7:0]         pos_r, pos_nxt;
  logic               valid_r, valid_nxt;
  logic [GROUP_W-1:0] group_r, group_nxt;
  logic [COUNT_W-1:0] count_r, count_nxt;
  logic [2:0]         status_r, status_nxt;
  logic               last_r, last_nxt;

  logic               load_ok;
  logic               fire;
  logic [7:0]         rem;
  logic [7:0]         cnt;
  logic               odd;
  logic [7:0]         pix;

  assign load_ok = !valid_r || !out_stall;
  assign fire = load_ok && !empty;
  assign rem = head.len - pos_r;
  assign cnt = (rem > LANES_B) ? LANES_B : rem;

  always_comb begin
    group_nxt = '0;
    odd = 1'b0;
    pix = 8'd0;
    for (int c = 0; c < LANES; c++) begin
      odd = pos_r[0] ^ 1'(c & 1);
      pix = head.r4 ? {4'd0, (odd ? head.value[3:0] : head.value[7:4])} : head.value;
      if (8'(c) < cnt) begin
        group_nxt[8*c +: 8] = pix;
      end
    end
  end

  always_comb begin
    pos_nxt = pos_r;
    valid_nxt = valid_r && out_stall;
    count_nxt = count_r;
    status_nxt = status_r;
    last_nxt = last_r;
    pop = 1'b0;
    if (fire) begin
      valid_nxt = 1'b1;
      if (rem != 8'd0) begin
        count_nxt = COUNT_W'(cnt);
        status_nxt = ST_DATA;
        if (rem <= LANES_B && head.st == ST_DATA) begin
          last_nxt = 1'b1;
          pop = 1'b1;
          pos_nxt = 8'd0;
        end else begin
          last_nxt = 1'b0;
          pos_nxt = pos_r + cnt;
        end
      end else begin
        count_nxt = '0;
        status_nxt = head.st;
        last_nxt = 1'b1;
        pop = 1'b1;
        pos_nxt = 8'd0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      group_r <= (rem != 8'd0) ? group_nxt : '0;
      count_r <= count_nxt;
      status_r <= status_nxt;
      last_r <= last_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= 8'd0;
      valid_r <= 1'b0;
    end else begin
      pos_r <= pos_nxt;
      valid_r <= valid_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_pixel_group = group_r;
  assign out_pixel_count = count_r;
  assign out_status = status_r;
  assign out_last_of_run = last_r;

endmodule

// ===== hdl/bmp_rle_line_decoder.sv =====
// Decodes one BMP RLE8 or RLE4 scan line, one compressed byte per input beat.
// A byte is classified in the cycle it is taken; a byte that yields pixels or
// a status queues one job (up to 4 wait), so bytes flow in one per cycle while
// the queue has room. Pixels leave in groups of up to LANES, one group per
// cycle while out_stall is low: a run of n pixels leaves as ceil(n / LANES)
// groups, plus a status beat if one follows; the output group emitter sets the
// sustained rate. Every status (end of line, end of bitmap, delta, overflow,
// truncated) restarts the line state. Write configuration only while idle.
module bmp_rle_line_decoder #(
  parameter int unsigned LANES = brle_pkg::LANES_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic                          cfg_index,
  input  logic [15:0]                   cfg_wdata,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [7:0]                    in_code_byte,
  input  logic                          in_stream_end,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [brle_pkg::GROUP_W-1:0]  out_pixel_group,
  output logic [brle_pkg::COUNT_W-1:0]  out_pixel_count,
  output logic [2:0]                    out_status,
  output logic                          out_last_of_run
);
  import brle_pkg::*;

  logic        rle4_mode_r;
  logic [15:0] line_capacity_r;
  logic        accept;
  logic        push;
  logic        pop;
  logic        q_empty;
  logic        q_full;
  cmd_t        push_cmd;
  cmd_t        head;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rle4_mode_r <= 1'b0;
      line_capacity_r <= 16'd0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_RLE4_MODE:     rle4_mode_r <= cfg_wdata[0];
        CFG_LINE_CAPACITY: line_capacity_r <= cfg_wdata;
        default:           line_capacity_r <= line_capacity_r;
      endcase
    end
  end

  assign in_stall = q_full;
  assign accept = in_valid && !q_full;

  brle_front #(
    .LANES(LANES)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .rle4_mode    (rle4_mode_r),
    .line_capacity(line_capacity_r),
    .accept       (accept),
    .code_byte    (in_code_byte),
    .stream_end   (in_stream_end),
    .push         (push),
    .cmd          (push_cmd)
  );

  brle_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .push_cmd(push_cmd),
    .pop     (pop),
    .head    (head),
    .empty   (q_empty),
    .full    (q_full)
  );

  brle_back #(
    .LANES(LANES)
  ) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .head           (head),
    .empty          (q_empty),
    .pop            (pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_pixel_group(out_pixel_group),
    .out_pixel_count(out_pixel_count),
    .out_status     (out_status),
    .out_last_of_run(out_last_of_run)
  );

endmodule
